[rtl/mcad_pkg.sv]
// shared types, constants and helpers of the additive circle draw unit
`timescale 1ns / 1ps
`default_nettype none

package mcad_pkg;

   // frame store geometry
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // field widths fixed by the interface
   localparam int DIM_W   = 7;
   localparam int COORD_W = 6;
   localparam int CHAN_W  = 8;
   localparam int STEP_W  = $clog2(DIM_W);
   localparam int ERR_W   = 10;

   // register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // item kinds
   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] cen_x;
      logic [COORD_W-1:0] cen_y;
      logic [COORD_W-1:0] radius;
      rgb_type            color;
      logic [COORD_W-1:0] read_x;
      logic [COORD_W-1:0] read_y;
   } req_item_type;

   // one access of the frame store pipeline
   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic [ADDR_W-1:0] addr;
      rgb_type           color;
   } pix_op_type;

   typedef struct packed {
      logic    valid;
      rgb_type pixel;
   } pix_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_PLOT,
      ST_READ,
      ST_RWAIT,
      ST_DONE
   } seq_state_type;

   // active dimension: zero counts as one, larger than the store as the store
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (int'(v) > maxv) r = DIM_W'(maxv);
      else r = v;
      return r;
   endfunction

   // column major pixel address
   function automatic logic [ADDR_W-1:0] pix_addr(input logic [DIM_W-1:0] col,
                                                  input logic [DIM_W-1:0] row);
      logic [ADDR_W+DIM_W:0] t;
      t = (ADDR_W+DIM_W+1)'(col) * (ADDR_W+DIM_W+1)'(MAX_HEIGHT) + (ADDR_W+DIM_W+1)'(row);
      return t[ADDR_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/mcad_col_mod.sv]
// restoring remainder unit, one compare and subtract per cycle
`timescale 1ns / 1ps
`default_nettype none

module mcad_col_mod (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mcad_pkg::DIM_W-1:0] value,
   input  wire logic [mcad_pkg::DIM_W-1:0] divisor,
   output logic                           done,
   output logic [mcad_pkg::DIM_W-1:0]     result
);
   import mcad_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   k_ff, k_in;
   logic [DIM_W-1:0]    rem_ff, rem_in;
   logic [DIM_W-1:0]    div_ff, div_in;
   logic [2*DIM_W-1:0]  shifted;

   // subtract the divisor shifted by k where it fits
   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      shifted = {{DIM_W{1'b0}}, div_ff} << k_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = STEP_W'(DIM_W - 1);
         rem_in  = value;
         div_in  = divisor;
      end else if (busy_ff) begin
         if ({{DIM_W{1'b0}}, rem_ff} >= shifted) rem_in = rem_ff - shifted[DIM_W-1:0];
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff   <= k_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

`default_nettype wire

[rtl/mcad_pixel_pipe.sv]
// frame store memory with read-modify-write pipeline and clearing pass
`timescale 1ns / 1ps
`default_nettype none

module mcad_pixel_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mcad_pkg::pix_op_type op,
   output mcad_pkg::pix_rsp_type     rsp,
   output logic                      clear_busy
);
   import mcad_pkg::*;

   rgb_type             mem [DEPTH];
   rgb_type             mem_q_ff;

   logic                b_valid_ff, b_read_ff;
   logic [ADDR_W-1:0]   b_addr_ff;
   rgb_type             b_color_ff;

   logic                wr_valid_ff;
   logic [ADDR_W-1:0]   wr_addr_ff;
   rgb_type             wr_data_ff;

   logic                clr_active_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;

   rgb_type             base, sum;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   rgb_type             mem_wd;

   // memory port: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[op.addr];
   end

   // forward last cycle's write, the read missed it
   always_comb begin
      base = (wr_valid_ff && wr_addr_ff == b_addr_ff) ? wr_data_ff : mem_q_ff;
      sum.red   = sat_add(base.red, b_color_ff.red);
      sum.green = sat_add(base.green, b_color_ff.green);
      sum.blue  = sat_add(base.blue, b_color_ff.blue);
      mem_we = clr_active_ff || (b_valid_ff && !b_read_ff);
      mem_wa = clr_active_ff ? clr_addr_ff : b_addr_ff;
      mem_wd = clr_active_ff ? rgb_type'('0) : sum;
   end

   // stage registers and clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         wr_valid_ff   <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         b_valid_ff  <= op.valid && !clr_active_ff;
         wr_valid_ff <= b_valid_ff && !b_read_ff && !clr_active_ff;
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) clr_active_ff <= 1'b0;
         end
      end
      b_read_ff  <= op.is_read;
      b_addr_ff  <= op.addr;
      b_color_ff <= op.color;
      wr_addr_ff <= b_addr_ff;
      wr_data_ff <= sum;
   end

   assign rsp.valid  = b_valid_ff && b_read_ff;
   assign rsp.pixel  = base;
   assign clear_busy = clr_active_ff;

endmodule

`default_nettype wire

[rtl/mcad_ring_seq.sv]
// item sequencer: midpoint ring stepping, octant points, reads and result register
`timescale 1ns / 1ps
`default_nettype none

module mcad_ring_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire mcad_pkg::req_item_type      item,
   input  wire logic [mcad_pkg::DIM_W-1:0]  width_act,
   input  wire logic [mcad_pkg::DIM_W-1:0]  height_act,
   input  wire logic                        clear_busy,
   output mcad_pkg::pix_op_type             op,
   input  wire mcad_pkg::pix_rsp_type       pix_rsp,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output mcad_pkg::rgb_type                out_pixel
);
   import mcad_pkg::*;

   seq_state_type          state_ff, state_in;
   logic [COORD_W-1:0]     cy_ff, cy_in;
   logic [COORD_W-1:0]     rad_ff, rad_in;
   logic [COORD_W-1:0]     a_ff, a_in;
   logic [DIM_W-1:0]       d_ff, d_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [DIM_W-1:0]       pa_ff, pa_in, ma_ff, ma_in, pd_ff, pd_in, md_ff, md_in;
   logic [2:0]             oct_ff, oct_in;
   logic                   single_ff, single_in;
   rgb_type                color_ff, color_in;
   logic [COORD_W-1:0]     rx_ff, rx_in, ry_ff, ry_in;
   rgb_type                res_ff, res_in;
   logic                   out_valid_ff, out_valid_in;
   rgb_type                out_pixel_ff, out_pixel_in;

   logic                   accept, mod_start, mods_done, cx_done, rad_done;
   logic [DIM_W-1:0]       cx_wrap, rad_wrap;
   logic [DIM_W:0]         pa_sum;
   logic signed [DIM_W:0]  ma_diff;
   logic signed [8:0]      row;
   logic [DIM_W-1:0]       col;
   logic                   row_ok;
   logic [DIM_W-1:0]       d_nx;
   logic [COORD_W-1:0]     a_nx;
   logic signed [ERR_W-1:0] t_err;
   logic [DIM_W-1:0]       w_top;

   assign accept    = in_valid && in_ready;
   assign mod_start = accept && item.mode == MODE_DRAW;
   assign mods_done = cx_done && rad_done;
   assign w_top     = width_act - DIM_W'(1);

   // center column and radius reduced modulo the active width
   mcad_col_mod u_cx_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .value   ({1'b0, item.cen_x}),
      .divisor (width_act),
      .done    (cx_done),
      .result  (cx_wrap)
   );

   mcad_col_mod u_rad_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .value   ({1'b0, item.radius}),
      .divisor (width_act),
      .done    (rad_done),
      .result  (rad_wrap)
   );

   // point of the current octant
   always_comb begin
      case (oct_ff)
         3'd0: begin col = pa_ff; row = $signed({3'b0, cy_ff}) + $signed({2'b0, d_ff}); end
         3'd1: begin col = pd_ff; row = $signed({3'b0, cy_ff}) + $signed({3'b0, a_ff}); end
         3'd2: begin col = ma_ff; row = $signed({3'b0, cy_ff}) + $signed({2'b0, d_ff}); end
         3'd3: begin col = md_ff; row = $signed({3'b0, cy_ff}) + $signed({3'b0, a_ff}); end
         3'd4: begin col = ma_ff; row = $signed({3'b0, cy_ff}) - $signed({2'b0, d_ff}); end
         3'd5: begin col = md_ff; row = $signed({3'b0, cy_ff}) - $signed({3'b0, a_ff}); end
         3'd6: begin col = pa_ff; row = $signed({3'b0, cy_ff}) - $signed({2'b0, d_ff}); end
         3'd7: begin col = pd_ff; row = $signed({3'b0, cy_ff}) - $signed({3'b0, a_ff}); end
         default: begin col = pa_ff; row = '0; end
      endcase
      row_ok = !row[8] && (row[7:0] < {1'b0, height_act});
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      cy_in        = cy_ff;
      rad_in       = rad_ff;
      a_in         = a_ff;
      d_in         = d_ff;
      err_in       = err_ff;
      pa_in        = pa_ff;
      ma_in        = ma_ff;
      pd_in        = pd_ff;
      md_in        = md_ff;
      oct_in       = oct_ff;
      single_in    = single_ff;
      color_in     = color_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_pixel_in = out_pixel_ff;
      in_ready     = 1'b0;
      op           = '0;
      pa_sum       = '0;
      ma_diff      = '0;
      d_nx         = d_ff + DIM_W'(1);
      a_nx         = a_ff - COORD_W'(1);
      t_err        = '0;

      case (state_ff)
         ST_IDLE: begin
            in_ready = !clear_busy;
            if (accept) begin
               cy_in    = item.cen_y;
               rad_in   = item.radius;
               color_in = item.color;
               rx_in    = item.read_x;
               ry_in    = item.read_y;
               if (item.mode == MODE_DRAW) begin
                  state_in = ST_MOD;
               end else if ({1'b0, item.read_x} < width_act &&
                            {1'b0, item.read_y} < height_act) begin
                  state_in = ST_READ;
               end else begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end

         // start columns of the four column tracks
         ST_MOD: begin
            if (mods_done) begin
               pa_sum  = {1'b0, cx_wrap} + {1'b0, rad_wrap};
               pa_in   = (pa_sum >= {1'b0, width_act}) ?
                         pa_sum[DIM_W-1:0] - width_act : pa_sum[DIM_W-1:0];
               ma_diff = $signed({1'b0, cx_wrap}) - $signed({1'b0, rad_wrap});
               ma_in   = ma_diff[DIM_W] ? ma_diff[DIM_W-1:0] + width_act : ma_diff[DIM_W-1:0];
               pd_in     = cx_wrap;
               md_in     = cx_wrap;
               a_in      = rad_ff;
               d_in      = '0;
               err_in    = ERR_W'(1) - $signed({{(ERR_W-COORD_W){1'b0}}, rad_ff});
               oct_in    = '0;
               single_in = (rad_ff == '0);
               state_in  = ST_PLOT;
            end
         end

         // one octant point per cycle, then one midpoint step
         ST_PLOT: begin
            op.valid   = row_ok;
            op.is_read = 1'b0;
            op.addr    = pix_addr(col, row[DIM_W-1:0]);
            op.color   = color_ff;
            oct_in     = oct_ff + 3'd1;
            if (single_ff) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else if (oct_ff == 3'd7) begin
               d_in  = d_nx;
               pd_in = (pd_ff == w_top) ? '0 : pd_ff + DIM_W'(1);
               md_in = (md_ff == '0) ? w_top : md_ff - DIM_W'(1);
               if (err_ff[ERR_W-1]) begin
                  err_in = err_ff + $signed({2'b0, d_nx, 1'b1});
               end else begin
                  a_in   = a_nx;
                  pa_in  = (pa_ff == '0) ? w_top : pa_ff - DIM_W'(1);
                  ma_in  = (ma_ff == w_top) ? '0 : ma_ff + DIM_W'(1);
                  t_err  = $signed({3'b0, d_nx}) - $signed({4'b0, a_nx}) + ERR_W'(1);
                  err_in = err_ff + (t_err <<< 1);
               end
               if ({1'b0, (err_ff[ERR_W-1] ? a_ff : a_nx)} < d_nx) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end

         ST_READ: begin
            op.valid   = 1'b1;
            op.is_read = 1'b1;
            op.addr    = pix_addr({1'b0, rx_ff}, {1'b0, ry_ff});
            state_in   = ST_RWAIT;
         end

         ST_RWAIT: begin
            if (pix_rsp.valid) begin
               res_in   = pix_rsp.pixel;
               state_in = ST_DONE;
            end
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_pixel_in = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cy_ff        <= cy_in;
      rad_ff       <= rad_in;
      a_ff         <= a_in;
      d_ff         <= d_in;
      err_ff       <= err_in;
      pa_ff        <= pa_in;
      ma_ff        <= ma_in;
      pd_ff        <= pd_in;
      md_ff        <= md_in;
      oct_ff       <= oct_in;
      single_ff    <= single_in;
      color_ff     <= color_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      res_ff       <= res_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;

endmodule

`default_nettype wire

[rtl/midpoint_circle_additive_draw_unit.sv]
// top level of the additive midpoint circle draw unit
// Usage:
//  req channel: one item per handshake. tuser = mode (0 draw circle, 1 read
//  one pixel). A draw adds its color, saturating, to every octant point of
//  a midpoint circle in a 64 x 64 RGB frame store; columns wrap modulo the
//  active width, rows outside the active height are skipped.
//  rsp channel: exactly one item per request: the pixel read, or zero
//  after a draw.
//  csr channel: index 0 active width, index 1 active height (reset 64);
//  always ready, to be written only while no item is in flight.
//  Throughput: one item at a time; the next item is taken in the cycle its
//  predecessor's result appears. A draw first reduces its center column and
//  radius modulo the active width, then plots one octant point per cycle
//  through the single frame store read-modify-write; at radius zero it plots
//  a single point.
//  Reset: the frame store is cleared by a sweep, one pixel per cycle;
//  req_tready stays low until it ends.
//  Stall: a result waits in the output register while the next item is
//  taken; a finished item waits for that register to empty.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_additive_draw_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cen_x, cen_y, radius, add_red, add_green, add_blue, read_x, read_y, zero pad
   input  wire logic [55:0] req_tdata,
   // mode
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pixel_red, pixel_green, pixel_blue
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);
   import mcad_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0] width_act, height_act;
   req_item_type     item;
   pix_op_type       op;
   pix_rsp_type      pix_rsp;
   rgb_type          out_pixel;
   logic             clear_busy;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_WIDTH);
         height_ff <= DIM_W'(MAX_HEIGHT);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data;
            REG_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign width_act  = clamp_dim(width_ff, MAX_WIDTH);
   assign height_act = clamp_dim(height_ff, MAX_HEIGHT);

   // request unpacking
   always_comb begin
      item.mode        = req_tuser;
      item.cen_x       = req_tdata[5:0];
      item.cen_y       = req_tdata[11:6];
      item.radius      = req_tdata[17:12];
      item.color.red   = req_tdata[25:18];
      item.color.green = req_tdata[33:26];
      item.color.blue  = req_tdata[41:34];
      item.read_x      = req_tdata[47:42];
      item.read_y      = req_tdata[53:48];
   end

   mcad_ring_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .item       (item),
      .width_act  (width_act),
      .height_act (height_act),
      .clear_busy (clear_busy),
      .op         (op),
      .pix_rsp    (pix_rsp),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_pixel  (out_pixel)
   );

   mcad_pixel_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .rsp        (pix_rsp),
      .clear_busy (clear_busy)
   );

   assign rsp_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};

   // no item taken while the frame store is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !(req_tvalid && req_tready))
      else $error("item accepted during frame store clear");

   // no pixel access issued while the clearing sweep owns the write port
   a_no_op_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !op.valid)
      else $error("pixel access during frame store clear");

   // a read result follows a read access issued in the previous cycle
   a_read_follows_op: assert property (@(posedge clock) disable iff (reset)
      pix_rsp.valid |-> $past(op.valid && op.is_read))
      else $error("pixel read result without a read access");

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the additive midpoint circle draw unit
`timescale 1ns / 1ps

module testbench;
   import mcad_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 800;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 145;

   // frame store predictor with a queue of expected pixels
   class frame_scoreboard;
      rgb_type frame [0:DEPTH-1];
      rgb_type pixel_q [$];
      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      int errors;

      function new();
         foreach (frame[i]) frame[i] = '0;
         width_reg = 7'd64;
         height_reg = 7'd64;
         errors = 0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void write_register(logic idx, logic [DIM_W-1:0] value);
         if (idx == REG_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      // zero acts as one, oversize acts as the store size
      function int active_dim(logic [DIM_W-1:0] v, int maxv);
         if (v == 0) return 1;
         if (int'(v) > maxv) return maxv;
         return int'(v);
      endfunction

      function int active_width();
         return active_dim(width_reg, MAX_WIDTH);
      endfunction

      function logic [7:0] clip_add(logic [7:0] a, logic [7:0] b);
         int s;
         s = int'(a) + int'(b);
         return (s > 255) ? 8'd255 : s[7:0];
      endfunction

      // columns wrap, rows outside the active height are dropped
      function void add_point(int x, int y, rgb_type c);
         int w, h, px, idx;
         w = active_dim(width_reg, MAX_WIDTH);
         h = active_dim(height_reg, MAX_HEIGHT);
         px = ((x % w) + w) % w;
         if (y < 0 || y >= h) return;
         idx = px * MAX_HEIGHT + y;
         frame[idx].red = clip_add(frame[idx].red, c.red);
         frame[idx].green = clip_add(frame[idx].green, c.green);
         frame[idx].blue = clip_add(frame[idx].blue, c.blue);
      endfunction

      function void trace_ring(int cx, int cy, int rad, rgb_type c);
         int a, d, err;
         a = rad;
         d = 0;
         err = 1 - rad;
         if (rad == 0) begin
            add_point(cx, cy, c);
            return;
         end
         while (a >= d) begin
            add_point(cx + a, cy + d, c);
            add_point(cx + d, cy + a, c);
            add_point(cx - a, cy + d, c);
            add_point(cx - d, cy + a, c);
            add_point(cx - a, cy - d, c);
            add_point(cx - d, cy - a, c);
            add_point(cx + a, cy - d, c);
            add_point(cx + d, cy - a, c);
            d++;
            if (err < 0) begin
               err += 2 * d + 1;
            end else begin
               a--;
               err += 2 * (d - a + 1);
            end
         end
      endfunction

      // an accepted item: update the frame, queue the pixel it returns
      function void note_request(logic mode, logic [5:0] cx, logic [5:0] cy,
                                 logic [5:0] rad, rgb_type c, logic [5:0] rx,
                                 logic [5:0] ry);
         rgb_type px;
         px = '0;
         if (mode == MODE_DRAW) begin
            trace_ring(int'(cx), int'(cy), int'(rad), c);
         end else if (int'(rx) < active_dim(width_reg, MAX_WIDTH) &&
                      int'(ry) < active_dim(height_reg, MAX_HEIGHT)) begin
            px = frame[int'(rx) * MAX_HEIGHT + int'(ry)];
         end
         pixel_q.push_back(px);
      endfunction

      task check_result(logic [23:0] data);
         rgb_type want;
         if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", data));
            return;
         end
         want = pixel_q.pop_front();
         if (data[7:0] !== want.red)
            report_mismatch($sformatf("red %0d, expected %0d", data[7:0], want.red));
         if (data[15:8] !== want.green)
            report_mismatch($sformatf("green %0d, expected %0d", data[15:8], want.green));
         if (data[23:16] !== want.blue)
            report_mismatch($sformatf("blue %0d, expected %0d", data[23:16], want.blue));
      endtask

      function int pending();
         return pixel_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [6:0] csr_data = '0;

   frame_scoreboard sb;
   int req_gap_max = 6;
   int rsp_gap_max = 6;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int rsp_wait = 0;
   int cycle_count = 0;

   logic [6:0] phase_width [0:PHASES-1] = '{7'd0, 7'd127, 7'd37, 7'd1,
                                           7'd100, 7'd13, 7'd64, 7'd2};
   logic [6:0] phase_height [0:PHASES-1] = '{7'd127, 7'd0, 7'd23, 7'd1,
                                            7'd50, 7'd64, 7'd64, 7'd37};

   midpoint_circle_additive_draw_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: random stalls per item plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
            rsp_wait = $urandom_range(0, rsp_gap_max);
         end else if (!rsp_tready && rsp_wait > 0) begin
            rsp_wait--;
         end
         if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (rsp_wait == 0);
         end
      end
   end

   // offer one item and hold it until accepted
   task automatic send_request(input logic mode, input logic [5:0] cx, input logic [5:0] cy,
                               input logic [5:0] rad, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b,
                               input logic [5:0] rx, input logic [5:0] ry);
      int gap;
      rgb_type c;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {2'b00, ry, rx, b, g, r, rad, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      c.red = r;
      c.green = g;
      c.blue = b;
      sb.note_request(mode, cx, cy, rad, c, rx, ry);
   endtask

   // sender pauses until every expected pixel is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int roll, dx, dy, w, k;
      int last_cx, last_cy, last_r;
      logic [5:0] cx, cy, rad, rx, ry;
      logic [7:0] r, g, b;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: single pixel, largest circle, repeated points, wrap, extremes
      send_request(MODE_DRAW, 6'd0, 6'd0, 6'd0, 8'd1, 8'd2, 8'd3, 6'd63, 6'd63);
      send_request(MODE_READ, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255, 6'd0, 6'd0);
      send_request(MODE_DRAW, 6'd63, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255, 6'd0, 6'd0);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd62, 6'd63);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd63, 6'd0);
      send_request(MODE_DRAW, 6'd10, 6'd10, 6'd1, 8'd200, 8'd100, 8'd0, 6'd0, 6'd0);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd11, 6'd10);
      send_request(MODE_DRAW, 6'd10, 6'd10, 6'd1, 8'd200, 8'd100, 8'd0, 6'd63, 6'd63);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd11, 6'd10);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd10, 6'd10);
      send_request(MODE_DRAW, 6'd5, 6'd40, 6'd7, 8'd0, 8'd0, 8'd128, 6'd21, 6'd42);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd12, 6'd40);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd5, 6'd47);
      send_request(MODE_DRAW, 6'd0, 6'd32, 6'd2, 8'd255, 8'd0, 8'd255, 6'd0, 6'd0);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd62, 6'd32);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd0, 6'd63);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd63, 6'd63);
      send_request(MODE_DRAW, 6'd32, 6'd0, 6'd5, 8'd17, 8'd34, 8'd51, 6'd0, 6'd0);
      send_request(MODE_READ, 6'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 6'd32, 6'd5);
      wait_for_results();

      last_cx = 32;
      last_cy = 32;
      last_r = 5;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_register(REG_WIDTH, phase_width[phase]);
         write_register(REG_HEIGHT, phase_height[phase]);
         // some phases run without random gaps on either side
         req_gap_max = (phase % 3 == 1) ? 0 : 6;
         rsp_gap_max = (phase % 3 == 1) ? 0 : 6;
         if (phase == PHASES - 1) holds_asked++;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == PHASE_ITEMS / 2) wait_for_results();
            roll = $urandom_range(0, 99);
            w = sb.active_width();
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            rx = 6'($urandom_range(0, 63));
            ry = 6'($urandom_range(0, 63));
            if (roll < 40) begin
               // new circle, mostly small; sometimes redraw the last one
               if ($urandom_range(0, 3) != 0) begin
                  last_cx = $urandom_range(0, 63);
                  last_cy = $urandom_range(0, 63);
                  last_r = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
                                                       : $urandom_range(11, 63);
               end
               cx = 6'(last_cx);
               cy = 6'(last_cy);
               rad = 6'(last_r);
               send_request(MODE_DRAW, cx, cy, rad, r, g, b, rx, ry);
            end else if (roll < 85) begin
               // read back a point of the last circle, or its center
               k = $urandom_range(0, 4);
               dx = (k == 0) ? last_r : (k == 2) ? -last_r : 0;
               dy = (k == 1) ? last_r : (k == 3) ? -last_r : 0;
               rx = 6'((((last_cx + dx) % w) + w) % w);
               ry = 6'((last_cy + dy) & 63);
               cx = 6'($urandom_range(0, 63));
               cy = 6'($urandom_range(0, 63));
               rad = 6'($urandom_range(0, 63));
               send_request(MODE_READ, cx, cy, rad, r, g, b, rx, ry);
            end else begin
               cx = 6'($urandom_range(0, 63));
               cy = 6'($urandom_range(0, 63));
               rad = 6'($urandom_range(0, 63));
               send_request(MODE_READ, cx, cy, rad, r, g, b, rx, ry);
            end
         end
         wait_for_results();
      end

      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
